FILE: rtl/core/cobs_pkg.sv
package cobs_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W = 11;
  localparam logic [DATA_W-1:0] FULL_CODE = 8'hFF;
  localparam int MAX_FRAME_LEN_DEF = 1024;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0] dec_byte;
    logic              has_byte;
    logic              last_result;
    logic              bad_frame;
    logic [LEN_W-1:0]  decoded_len;
  } res_t;

  // one queued request: one or two results of a single input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } ent_t;

endpackage

FILE: rtl/core/cobs_fe.sv
module cobs_fe #(
  parameter int MAX_FRAME_LEN = cobs_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cobs_pkg::DATA_W-1:0] in_enc_byte,
  input  logic                        in_frame_end,
  input  logic                        q_full,
  output logic                        q_push,
  output cobs_pkg::ent_t              q_ent
);

  localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
  localparam int WIDE_W = (CNT_W > cobs_pkg::LEN_W) ? CNT_W : cobs_pkg::LEN_W;

  logic [cobs_pkg::DATA_W-1:0] bytes_left_r, bytes_left_nxt;
  logic                        group_full_r, group_full_nxt;
  logic [CNT_W-1:0]            out_count_r, out_count_nxt;

  logic             data_byte;
  logic             closed;
  logic             ins_zero;
  logic             bad;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic [WIDE_W-1:0] cnt_wide;
  logic             nres_any;
  logic             accept;
  cobs_pkg::res_t   res_data, res_zero, res_mark;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    group_full_nxt = group_full_r;
    closed = 1'b0;
    data_byte = 1'b0;
    if (bytes_left_r == '0) begin
      if (in_enc_byte <= cobs_pkg::DATA_W'(1)) begin
        closed = 1'b1;
        group_full_nxt = 1'b0;
      end else begin
        bytes_left_nxt = in_enc_byte - cobs_pkg::DATA_W'(1);
        group_full_nxt = (in_enc_byte == cobs_pkg::FULL_CODE);
      end
    end else begin
      data_byte = 1'b1;
      bytes_left_nxt = bytes_left_r - cobs_pkg::DATA_W'(1);
      closed = (bytes_left_r == cobs_pkg::DATA_W'(1));
    end

    // saturating count at MAX_FRAME_LEN + 1
    cnt_a = out_count_r;
    if (data_byte && (out_count_r <= CNT_W'(MAX_FRAME_LEN))) begin
      cnt_a = out_count_r + CNT_W'(1);
    end
    ins_zero = !in_frame_end && closed && !group_full_nxt;
    cnt_b = cnt_a;
    if (ins_zero && (cnt_a <= CNT_W'(MAX_FRAME_LEN))) begin
      cnt_b = cnt_a + CNT_W'(1);
    end
    out_count_nxt = cnt_b;
    bad = (bytes_left_nxt != '0) || (cnt_a > CNT_W'(MAX_FRAME_LEN));

    // end of frame: back to the reset state
    if (in_frame_end) begin
      bytes_left_nxt = '0;
      group_full_nxt = 1'b0;
      out_count_nxt = '0;
    end
  end

  always_comb begin
    cnt_wide = WIDE_W'(cnt_a);

    res_data = '0;
    res_data.dec_byte = in_enc_byte;
    res_data.has_byte = 1'b1;

    res_zero = '0;
    res_zero.has_byte = 1'b1;

    res_mark = '0;
    res_mark.last_result = 1'b1;
    res_mark.bad_frame = bad;
    res_mark.decoded_len = bad ? '0 : cnt_wide[cobs_pkg::LEN_W-1:0];

    q_ent = '0;
    nres_any = 1'b1;
    if (data_byte) begin
      q_ent.r0 = res_data;
      if (in_frame_end) begin
        q_ent.two = 1'b1;
        q_ent.r1 = res_mark;
      end else if (ins_zero) begin
        q_ent.two = 1'b1;
        q_ent.r1 = res_zero;
      end
    end else if (in_frame_end) begin
      q_ent.r0 = res_mark;
    end else if (ins_zero) begin
      q_ent.r0 = res_zero;
    end else begin
      nres_any = 1'b0;
    end
  end

  assign q_push = accept && nres_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      group_full_r <= 1'b0;
      out_count_r <= '0;
    end else if (accept) begin
      bytes_left_r <= bytes_left_nxt;
      group_full_r <= group_full_nxt;
      out_count_r <= out_count_nxt;
    end
  end

endmodule

FILE: rtl/core/cobs_q.sv
module cobs_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cobs_pkg::ent_t push_ent,
  input  logic           pop,
  output cobs_pkg::ent_t pop_ent,
  output logic           full,
  output logic           empty
);

  cobs_pkg::ent_t                 mem_r [cobs_pkg::Q_DEPTH];
  logic [cobs_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cobs_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cobs_pkg::Q_CNT_W-1:0]  count_r, count_nxt;

  assign full = (count_r == cobs_pkg::Q_CNT_W'(cobs_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign pop_ent = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cobs_pkg::Q_PTR_W'(cobs_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + cobs_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cobs_pkg::Q_PTR_W'(cobs_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + cobs_pkg::Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + cobs_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cobs_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

FILE: rtl/core/cobs_be.sv
module cobs_be (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  cobs_pkg::ent_t               q_ent,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cobs_pkg::DATA_W-1:0]  out_dec_byte,
  output logic                         out_has_byte,
  output logic                         out_last_result,
  output logic                         out_bad_frame,
  output logic [cobs_pkg::LEN_W-1:0]   out_decoded_len
);

  logic           out_valid_r, out_valid_nxt;
  logic           pend_r, pend_nxt;
  cobs_pkg::res_t res_r, res_nxt;
  cobs_pkg::res_t pres_r, pres_nxt;
  logic           load;

  assign load = !out_valid_r || out_ready;
  assign q_pop = load && !pend_r && !q_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt = pend_r;
    res_nxt = res_r;
    pres_nxt = pres_r;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        res_nxt = pres_r;
        pend_nxt = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        res_nxt = q_ent.r0;
        pend_nxt = q_ent.two;
        pres_nxt = q_ent.r1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    pres_r <= pres_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_dec_byte = res_r.dec_byte;
  assign out_has_byte = res_r.has_byte;
  assign out_last_result = res_r.last_result;
  assign out_bad_frame = res_r.bad_frame;
  assign out_decoded_len = res_r.decoded_len;

endmodule

FILE: rtl/core/cobs_frame_decoder.sv
// Streaming COBS frame decoder.
// Input channel (in_valid/in_ready): one encoded byte per request, with
// in_frame_end high on the last byte of a frame. The first byte of each
// frame, and the byte after each finished group, is a code byte.
// Output channel (out_valid/out_ready): one result per request, either a
// decoded byte (out_has_byte high) or the end-of-frame marker
// (out_last_result high) carrying out_decoded_len and out_bad_frame.
// A byte gives zero, one or two results; a frame always ends in a marker.
// Each result is written to the queue and then to the output register
// before out_valid rises. The output register moves one result per
// cycle while out_ready is high, so a byte that yields a data byte plus
// an inserted zero or the marker leaves as two results in turn. A
// two-entry queue sits between the byte classifier and the output stage,
// so input keeps flowing while a result waits.
// Reset (rst_n low, synchronous) empties the queue, drops any pending
// result and returns the decoder to wait for a code byte.
// When out_ready is low the current result holds; the queue fills, then
// in_ready drops until the receiver takes results again.
module cobs_frame_decoder #(
  parameter int MAX_FRAME_LEN = cobs_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cobs_pkg::DATA_W-1:0] in_enc_byte,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cobs_pkg::DATA_W-1:0] out_dec_byte,
  output logic                        out_has_byte,
  output logic                        out_last_result,
  output logic                        out_bad_frame,
  output logic [cobs_pkg::LEN_W-1:0]  out_decoded_len
);

  logic           q_full, q_empty, q_push, q_pop;
  cobs_pkg::ent_t push_ent, pop_ent;

  cobs_fe #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_fe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_enc_byte (in_enc_byte),
    .in_frame_end(in_frame_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ent       (push_ent)
  );

  cobs_q u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ent(push_ent),
    .pop     (q_pop),
    .pop_ent (pop_ent),
    .full    (q_full),
    .empty   (q_empty)
  );

  cobs_be u_be (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_ent          (pop_ent),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dec_byte   (out_dec_byte),
    .out_has_byte   (out_has_byte),
    .out_last_result(out_last_result),
    .out_bad_frame  (out_bad_frame),
    .out_decoded_len(out_decoded_len)
  );

endmodule

FILE: rtl/core/cobs_chk.sv
module cobs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cobs_pkg::DATA_W-1:0] out_dec_byte,
  input logic                        out_has_byte,
  input logic                        out_last_result,
  input logic                        out_bad_frame,
  input logic [cobs_pkg::LEN_W-1:0]  out_decoded_len
);

  // reset drops any pending result
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dec_byte) &&
    $stable(out_has_byte) && $stable(out_last_result) &&
    $stable(out_bad_frame) && $stable(out_decoded_len))
    else $error("stalled result changed");

  // byte results and end markers are exclusive
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_byte != out_last_result))
    else $error("result is neither byte nor marker, or both");

  // a bad frame only flags on the marker and reports no length
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_frame |-> out_last_result && (out_decoded_len == '0))
    else $error("bad frame flag misplaced");

  // byte results carry no length
  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> (out_decoded_len == '0) && !out_bad_frame)
    else $error("byte result carries length");

endmodule

bind cobs_frame_decoder cobs_chk u_cobs_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_dec_byte   (out_dec_byte),
  .out_has_byte   (out_has_byte),
  .out_last_result(out_last_result),
  .out_bad_frame  (out_bad_frame),
  .out_decoded_len(out_decoded_len)
);
